// ===== src/ttr_pkg.sv =====
// ---------------------------------------------------------------------------
// ttr_pkg
// shared constants and types for the tiled triangle rasterizer
// ---------------------------------------------------------------------------
package ttr_pkg;

  localparam int FRAC_BITS  = 6;
  localparam int ADDR_W     = 10;
  localparam int WORD_W     = 32;
  localparam int POS_W      = 16;   // signed edge position, 8.6 plus sign/headroom
  localparam int DIV_W      = 15;   // dividend magnitude width (255 << 6)
  localparam int DY_W       = 7;
  localparam int STORE_WORDS = 1 << ADDR_W;

  localparam logic [WORD_W-1:0] PLANE_MASK = 32'h8888_8888;
  localparam logic [WORD_W-1:0] LEFT_FULL  = 32'h0FFF_FFFF;
  localparam logic [WORD_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;

  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // divider request / response between sequencer and divider
  typedef struct packed {
    logic                    start;
    logic signed [POS_W-1:0] num;
    logic [DY_W-1:0]         den;
  } ttr_div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [POS_W-1:0] quo;
  } ttr_div_rsp_t;

endpackage

// ===== src/tiled_triangle_rasterizer.sv =====
// ---------------------------------------------------------------------------
// tiled_triangle_rasterizer
// triangle fill into a tiled 4-bit frame store, with word readback
// ---------------------------------------------------------------------------
// usage: one input channel (in_valid/in_stall) takes draw or read items; one
// result channel (out_valid/out_stall) returns one word per item.
// at reset the block sweeps all 1024 words of the frame store to zero with
// in_stall high; after that it takes one item at a time.
// a read item goes through S_RD and S_RDW (registered store read) before its
// result shows, and the next item can be taken in the cycle after the result leaves.
// a draw item takes three compare-swap sort passes plus up to three slope
// divisions on the shared divider (start, 15 quotient bits, done), then per
// row an edge step and, per touched tile word, a read, a wait and a
// merge-write on the store.
// the result of a draw is zero. while out_stall is high the result is held
// and no new item is taken.
// ---------------------------------------------------------------------------
module tiled_triangle_rasterizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_x0,
  input  logic [6:0]  in_y0,
  input  logic [7:0]  in_x1,
  input  logic [6:0]  in_y1,
  input  logic [7:0]  in_x2,
  input  logic [6:0]  in_y2,
  input  logic [31:0] in_color,
  input  logic [9:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_RDW   = 4'd3;
  localparam logic [3:0] S_SORT  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DIVW  = 4'd6;
  localparam logic [3:0] S_ROW   = 4'd7;
  localparam logic [3:0] S_WRD   = 4'd8;
  localparam logic [3:0] S_WWAIT = 4'd9;
  localparam logic [3:0] S_WWR   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam int P = ttr_pkg::POS_W;

  logic [3:0]  state_r, state_nxt;
  logic [ttr_pkg::ADDR_W:0] clr_r, clr_nxt;
  logic [7:0]  vx_r [3], vx_nxt [3];
  logic [6:0]  vy_r [3], vy_nxt [3];
  logic [31:0] color_r, color_nxt;
  logic [9:0]  ridx_r, ridx_nxt;
  logic [1:0]  dsel_r, dsel_nxt;
  logic signed [P-1:0] da_r, da_nxt, db_r, db_nxt, dc_r, dc_nxt;
  logic signed [P-1:0] xa_r, xa_nxt, xb_r, xb_nxt;
  logic        lower_r, lower_nxt;
  logic [6:0]  y_r, y_nxt;
  logic [6:0]  rows_r, rows_nxt;
  logic [4:0]  t_r, t_nxt, ta_r, ta_nxt, tb_r, tb_nxt;
  logic [31:0] lm_r, lm_nxt, hm_r, hm_nxt;
  logic [31:0] rdata_r, rdata_nxt;
  logic        ovalid_r, ovalid_nxt;

  ttr_pkg::ttr_div_req_t dreq;
  ttr_pkg::ttr_div_rsp_t drsp;

  logic [ttr_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [31:0] rd_data, wr_data;
  logic        wr_en;

  ttr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  ttr_store u_store (
    .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  // row helpers
  logic [7:0]  plo, phi, lo, hi;
  logic [31:0] pat;
  logic [ttr_pkg::ADDR_W-1:0] base, waddr;
  logic [31:0] wmask;
  logic signed [P-1:0] xs;

  always_comb begin
    xs  = lower_r ? dc_r : da_r;
    plo = xa_r[ttr_pkg::FRAC_BITS+7:ttr_pkg::FRAC_BITS];
    phi = xb_r[ttr_pkg::FRAC_BITS+7:ttr_pkg::FRAC_BITS];
    lo  = (plo > phi) ? phi : plo;
    hi  = (plo > phi) ? plo : phi;
    pat = color_r & (ttr_pkg::PLANE_MASK >> y_r[6:5]);
    base = {y_r[4:3], 5'd0, y_r[2:0]};
    waddr = base | {2'd0, t_r, 3'd0};
    if (ta_r == tb_r)        wmask = lm_r & hm_r;
    else if (t_r == ta_r)    wmask = lm_r;
    else if (t_r == tb_r)    wmask = hm_r;
    else                     wmask = ttr_pkg::ALL_ONES;
  end

  // divider operands for edges a, b, c
  logic signed [P-1:0] num_sel;
  logic [6:0] den_sel;
  always_comb begin
    unique case (dsel_r)
      2'd0: begin
        num_sel = P'({vx_r[2], 6'd0}) - P'({vx_r[0], 6'd0});
        den_sel = vy_r[2] - vy_r[0];
      end
      2'd1: begin
        num_sel = P'({vx_r[1], 6'd0}) - P'({vx_r[0], 6'd0});
        den_sel = vy_r[1] - vy_r[0];
      end
      default: begin
        num_sel = P'({vx_r[2], 6'd0}) - P'({vx_r[1], 6'd0});
        den_sel = vy_r[2] - vy_r[1];
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    for (int i = 0; i < 3; i++) begin
      vx_nxt[i] = vx_r[i];
      vy_nxt[i] = vy_r[i];
    end
    color_nxt = color_r; ridx_nxt = ridx_r; dsel_nxt = dsel_r;
    da_nxt = da_r; db_nxt = db_r; dc_nxt = dc_r;
    xa_nxt = xa_r; xb_nxt = xb_r; lower_nxt = lower_r;
    y_nxt = y_r; rows_nxt = rows_r;
    t_nxt = t_r; ta_nxt = ta_r; tb_nxt = tb_r;
    lm_nxt = lm_r; hm_nxt = hm_r;
    rdata_nxt = rdata_r; ovalid_nxt = ovalid_r;
    dreq = '0;
    rd_addr = ridx_r;
    wr_en = 1'b0;
    wr_addr = waddr;
    wr_data = rd_data | (wmask & pat);
    unique case (state_r)
      S_CLR: begin
        wr_en = 1'b1;
        wr_addr = clr_r[ttr_pkg::ADDR_W-1:0];
        wr_data = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r[ttr_pkg::ADDR_W-1:0] == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          vx_nxt[0] = in_x0; vx_nxt[1] = in_x1; vx_nxt[2] = in_x2;
          vy_nxt[0] = in_y0; vy_nxt[1] = in_y1; vy_nxt[2] = in_y2;
          color_nxt = in_color;
          ridx_nxt = in_read_index;
          state_nxt = (in_kind == ttr_pkg::KIND_READ) ? S_RD : S_SORT;
        end
      end
      S_RD: state_nxt = S_RDW;
      S_RDW: begin
        rdata_nxt = rd_data;
        ovalid_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_SORT: begin
        // three compare-swap passes, one per cycle via dsel
        unique case (dsel_r)
          2'd0: if (vy_r[1] < vy_r[0]) begin
            vx_nxt[0] = vx_r[1]; vx_nxt[1] = vx_r[0];
            vy_nxt[0] = vy_r[1]; vy_nxt[1] = vy_r[0];
          end
          2'd1: if (vy_r[2] < vy_r[1]) begin
            vx_nxt[1] = vx_r[2]; vx_nxt[2] = vx_r[1];
            vy_nxt[1] = vy_r[2]; vy_nxt[2] = vy_r[1];
          end
          default: if (vy_r[1] < vy_r[0]) begin
            vx_nxt[0] = vx_r[1]; vx_nxt[1] = vx_r[0];
            vy_nxt[0] = vy_r[1]; vy_nxt[1] = vy_r[0];
          end
        endcase
        dsel_nxt = dsel_r + 2'd1;
        if (dsel_r == 2'd2) begin
          dsel_nxt = 2'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (vy_r[2] == vy_r[0]) begin
          rdata_nxt = '0; ovalid_nxt = 1'b1; state_nxt = S_OUT;
        end else if (den_sel == 7'd0) begin
          // flat edge, no slope needed
          dsel_nxt = dsel_r + 2'd1;
          if (dsel_r == 2'd2) state_nxt = S_ROW;
        end else begin
          dreq.start = 1'b1;
          dreq.num = num_sel;
          dreq.den = den_sel;
          state_nxt = S_DIVW;
        end
        if (dsel_r == 2'd0) begin
          y_nxt = vy_r[0];
          lower_nxt = (vy_r[1] == vy_r[0]);
          rows_nxt = (vy_r[1] == vy_r[0]) ? (vy_r[2] - vy_r[1]) : (vy_r[1] - vy_r[0]);
        end
      end
      S_DIVW: begin
        if (drsp.done) begin
          unique case (dsel_r)
            2'd0: begin
              db_nxt = drsp.quo;
              xb_nxt = $signed(P'({vx_r[0], 6'd0})) + (drsp.quo >>> 1);
            end
            2'd1: begin
              da_nxt = drsp.quo;
              if (!lower_r) xa_nxt = $signed(P'({vx_r[0], 6'd0})) + (drsp.quo >>> 1);
            end
            default: begin
              dc_nxt = drsp.quo;
              if (lower_r) xa_nxt = $signed(P'({vx_r[1], 6'd0})) + (drsp.quo >>> 1);
            end
          endcase
          dsel_nxt = dsel_r + 2'd1;
          state_nxt = (dsel_r == 2'd2) ? S_ROW : S_DIV;
        end
      end
      S_ROW: begin
        ta_nxt = lo[7:3];
        tb_nxt = hi[7:3];
        t_nxt  = lo[7:3];
        lm_nxt = ttr_pkg::ALL_ONES >> {lo[2:0], 2'b00};
        hm_nxt = ~(ttr_pkg::LEFT_FULL >> {hi[2:0], 2'b00});
        state_nxt = S_WRD;
      end
      S_WRD: begin
        rd_addr = waddr;
        state_nxt = S_WWAIT;
      end
      S_WWAIT: begin
        rd_addr = waddr;
        state_nxt = S_WWR;
      end
      S_WWR: begin
        wr_en = 1'b1;
        if (t_r != tb_r) begin
          t_nxt = t_r + 5'd1;
          state_nxt = S_WRD;
        end else begin
          y_nxt = y_r + 7'd1;
          xa_nxt = xa_r + xs;
          xb_nxt = xb_r + db_r;
          rows_nxt = rows_r - 7'd1;
          state_nxt = S_ROW;
          if (rows_r == 7'd1) begin
            if (!lower_r && (vy_r[2] != vy_r[1])) begin
              lower_nxt = 1'b1;
              rows_nxt = vy_r[2] - vy_r[1];
              xa_nxt = $signed(P'({vx_r[1], 6'd0})) + (dc_r >>> 1);
            end else begin
              rdata_nxt = '0; ovalid_nxt = 1'b1; state_nxt = S_OUT;
            end
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          ovalid_nxt = 1'b0;
          dsel_nxt = 2'd0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      dsel_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      dsel_r   <= dsel_nxt;
      ovalid_r <= ovalid_nxt;
    end
    for (int i = 0; i < 3; i++) begin
      vx_r[i] <= vx_nxt[i];
      vy_r[i] <= vy_nxt[i];
    end
    color_r <= color_nxt; ridx_r <= ridx_nxt;
    da_r <= da_nxt; db_r <= db_nxt; dc_r <= dc_nxt;
    xa_r <= xa_nxt; xb_r <= xb_nxt; lower_r <= lower_nxt;
    y_r <= y_nxt; rows_r <= rows_nxt;
    t_r <= t_nxt; ta_r <= ta_nxt; tb_r <= tb_nxt;
    lm_r <= lm_nxt; hm_r <= hm_nxt;
    rdata_r <= rdata_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = ovalid_r;
  assign out_read_data = rdata_r;

endmodule

// ===== src/ttr_div.sv =====
// ---------------------------------------------------------------------------
// ttr_div
// iterative signed divider, truncating toward zero, one quotient bit a cycle
// ---------------------------------------------------------------------------
module ttr_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ttr_pkg::ttr_div_req_t req,
  output ttr_pkg::ttr_div_rsp_t rsp
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [3:0]                 cnt_r, cnt_nxt;
  logic                       neg_r, neg_nxt;
  logic [ttr_pkg::DIV_W-1:0]  q_r, q_nxt;
  logic [ttr_pkg::DY_W:0]     rem_r, rem_nxt;
  logic [ttr_pkg::DY_W-1:0]   den_r, den_nxt;
  logic [ttr_pkg::DY_W+1:0]   trial;
  logic [ttr_pkg::POS_W-1:0]  mag;

  always_comb begin
    mag = req.num[ttr_pkg::POS_W-1] ? (~req.num + 1'b1) : req.num;
    trial = {rem_r, q_r[ttr_pkg::DIV_W-1]} - {2'b00, den_r};
  end

  // restoring division on the magnitude
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'(ttr_pkg::DIV_W);
      neg_nxt  = req.num[ttr_pkg::POS_W-1];
      q_nxt    = mag[ttr_pkg::DIV_W-1:0];
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      if (!trial[ttr_pkg::DY_W+1]) begin
        rem_nxt = trial[ttr_pkg::DY_W:0];
        q_nxt   = {q_r[ttr_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[ttr_pkg::DY_W-1:0], q_r[ttr_pkg::DIV_W-1]};
        q_nxt   = {q_r[ttr_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // sign restore
  logic signed [ttr_pkg::POS_W-1:0] qext;
  assign qext     = ttr_pkg::POS_W'({1'b0, q_r});
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? -qext : qext;

endmodule

// ===== src/ttr_store.sv =====
// ---------------------------------------------------------------------------
// ttr_store
// 1024 x 32 frame store with a registered read port and one write port
// ---------------------------------------------------------------------------
module ttr_store (
  input  logic                         clk,
  input  logic [ttr_pkg::ADDR_W-1:0]   rd_addr,
  output logic [ttr_pkg::WORD_W-1:0]   rd_data,
  input  logic                         wr_en,
  input  logic [ttr_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [ttr_pkg::WORD_W-1:0]   wr_data
);

  logic [ttr_pkg::WORD_W-1:0] mem [ttr_pkg::STORE_WORDS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/ttr_checker.sv =====
// ---------------------------------------------------------------------------
// ttr_checker
// port-level checks on the rasterizer handshakes
// ---------------------------------------------------------------------------
module ttr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_read_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("result changed while stalled");

  // no new item is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("item accepted with a result pending");

  // an accepted item is not answered in the very next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

endmodule

bind tiled_triangle_rasterizer ttr_checker u_ttr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_read_data(out_read_data)
);

// ===== verif/tiled_triangle_rasterizer_tb.sv =====
// ---------------------------------------------------------------------------
// tiled_triangle_rasterizer_tb
// draws triangles, reads words back; each result is checked against a fixed
// word or an in-bench rasterizer with its own store copy
// ---------------------------------------------------------------------------
module tiled_triangle_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int MAX_MISMATCH_SHOWN = 10;

  // one item of stimulus
  typedef struct {
    logic        kind;
    logic [7:0]  x0;
    logic [6:0]  y0;
    logic [7:0]  x1;
    logic [6:0]  y1;
    logic [7:0]  x2;
    logic [6:0]  y2;
    logic [31:0] color;
    logic [9:0]  read_index;
    logic        has_fixed;
    logic [31:0] fixed_data;
  } raster_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [7:0]  in_x0;
  logic [6:0]  in_y0;
  logic [7:0]  in_x1;
  logic [6:0]  in_y1;
  logic [7:0]  in_x2;
  logic [6:0]  in_y2;
  logic [31:0] in_color;
  logic [9:0]  in_read_index;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_read_data;

  logic [31:0] shadow_store [ttr_pkg::STORE_WORDS];
  logic [31:0] expected_words [$];
  int          mismatch_count = 0;
  int          idle_cycles;

  tiled_triangle_rasterizer DUT (.*);

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // arithmetic shift right that rounds toward minus infinity
  function automatic int floor_shift(int v, int s);
    return v >>> s;
  endfunction

  // or one span of a row into the shadow store
  function automatic void fill_row_span(int y, int ea, int eb, logic [31:0] pat);
    int lo, hi, tmp, ta, tb, t, base;
    logic [31:0] lm, hm;
    lo = floor_shift(ea, ttr_pkg::FRAC_BITS) & 8'hFF;
    hi = floor_shift(eb, ttr_pkg::FRAC_BITS) & 8'hFF;
    base = (y & 7) + ((y >> 3) & 3) * 256;
    if (lo > hi) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    ta = lo >> 3;
    tb = hi >> 3;
    lm = ttr_pkg::ALL_ONES >> (4 * (lo & 7));
    hm = ~(ttr_pkg::LEFT_FULL >> (4 * (hi & 7)));
    if (ta == tb) begin
      shadow_store[(base + ta * 8) & 10'h3FF] |= lm & hm & pat;
    end else begin
      for (t = ta + 1; t < tb; t++) shadow_store[(base + t * 8) & 10'h3FF] |= pat;
      shadow_store[(base + ta * 8) & 10'h3FF] |= lm & pat;
      shadow_store[(base + tb * 8) & 10'h3FF] |= hm & pat;
    end
  endfunction

  // rasterize one triangle into the shadow store
  function automatic void rasterize_triangle(raster_item_t it);
    int vx [3];
    int vy [3];
    int tmp, dyb, dya, dyc, da, db, dc, xa, xb, xc, i, y;
    logic [31:0] pat;
    vx[0] = it.x0; vy[0] = it.y0;
    vx[1] = it.x1; vy[1] = it.y1;
    vx[2] = it.x2; vy[2] = it.y2;
    if (vy[1] < vy[0]) begin
      tmp = vx[0]; vx[0] = vx[1]; vx[1] = tmp;
      tmp = vy[0]; vy[0] = vy[1]; vy[1] = tmp;
    end
    if (vy[2] < vy[1]) begin
      tmp = vx[1]; vx[1] = vx[2]; vx[2] = tmp;
      tmp = vy[1]; vy[1] = vy[2]; vy[2] = tmp;
      if (vy[1] < vy[0]) begin
        tmp = vx[0]; vx[0] = vx[1]; vx[1] = tmp;
        tmp = vy[0]; vy[0] = vy[1]; vy[1] = tmp;
      end
    end
    dyb = vy[2] - vy[0];
    if (dyb == 0) return;
    for (i = 0; i < 3; i++) vx[i] = vx[i] * (1 << ttr_pkg::FRAC_BITS);
    dya = vy[1] - vy[0];
    dyc = vy[2] - vy[1];
    db = (vx[2] - vx[0]) / dyb;
    xb = vx[0] + floor_shift(db, 1);
    y = vy[0];
    if (dya != 0) begin
      da = (vx[1] - vx[0]) / dya;
      xa = vx[0] + floor_shift(da, 1);
      for (i = 0; i < dya; i++) begin
        pat = it.color & (ttr_pkg::PLANE_MASK >> ((y >> 5) & 3));
        fill_row_span(y, xa, xb, pat);
        y++;
        xa += da;
        xb += db;
      end
    end
    if (dyc != 0) begin
      dc = (vx[2] - vx[1]) / dyc;
      xc = vx[1] + floor_shift(dc, 1);
      for (i = 0; i < dyc; i++) begin
        pat = it.color & (ttr_pkg::PLANE_MASK >> ((y >> 5) & 3));
        fill_row_span(y, xc, xb, pat);
        y++;
        xc += dc;
        xb += db;
      end
    end
  endfunction

  // expected word for one accepted item
  function automatic logic [31:0] predict_word(raster_item_t it);
    if (it.kind == ttr_pkg::KIND_READ) return shadow_store[it.read_index];
    rasterize_triangle(it);
    return '0;
  endfunction

  function automatic raster_item_t make_draw(int x0, int y0, int x1, int y1, int x2, int y2,
                                             logic [31:0] color);
    raster_item_t it;
    it.kind = ttr_pkg::KIND_DRAW;
    it.x0 = 8'(x0); it.y0 = 7'(y0); it.x1 = 8'(x1);
    it.y1 = 7'(y1); it.x2 = 8'(x2); it.y2 = 7'(y2);
    it.color = color;
    it.read_index = 10'($urandom);
    it.has_fixed = 1'b1;
    it.fixed_data = '0;
    return it;
  endfunction

  function automatic raster_item_t make_read(int idx, bit has_fixed, logic [31:0] data);
    raster_item_t it;
    it.kind = ttr_pkg::KIND_READ;
    it.x0 = 8'($urandom); it.y0 = 7'($urandom); it.x1 = 8'($urandom);
    it.y1 = 7'($urandom); it.x2 = 8'($urandom); it.y2 = 7'($urandom);
    it.color = $urandom;
    it.read_index = 10'(idx);
    it.has_fixed = has_fixed;
    it.fixed_data = data;
    return it;
  endfunction

  // mostly small triangles, a few large ones
  function automatic raster_item_t random_draw();
    int cx, cy, r;
    raster_item_t it;
    if ($urandom_range(0, 19) == 0) begin
      it = make_draw($urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 255),
                     $urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 127),
                     $urandom);
    end else begin
      r = $urandom_range(1, 20);
      cx = $urandom_range(0, 255 - r);
      cy = $urandom_range(0, 127 - r);
      it = make_draw(cx + $urandom_range(0, r), cy + $urandom_range(0, r),
                     cx + $urandom_range(0, r), cy + $urandom_range(0, r),
                     cx + $urandom_range(0, r), cy + $urandom_range(0, r), $urandom);
    end
    it.has_fixed = 1'b0;
    return it;
  endfunction

  // send one item and queue its expected word; sender_gap makes the stream bursty
  task automatic send_item(raster_item_t it);
    logic [31:0] want;
    in_valid      <= 1'b1;
    in_kind       <= it.kind;
    in_x0         <= it.x0;
    in_y0         <= it.y0;
    in_x1         <= it.x1;
    in_y1         <= it.y1;
    in_x2         <= it.x2;
    in_y2         <= it.y2;
    in_color      <= it.color;
    in_read_index <= it.read_index;
    do @(posedge clk); while (in_stall);
    want = predict_word(it);
    if (it.has_fixed) want = it.fixed_data;
    expected_words.push_back(want);
  endtask

  int burst_left;
  task automatic sender_gap();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
    burst_left = $urandom_range(0, 15);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_MISMATCH_SHOWN)
          $display("unexpected result read_data=%h", out_read_data);
      end else begin
        if (out_read_data !== expected_words[0]) begin
          mismatch_count++;
          if (mismatch_count <= MAX_MISMATCH_SHOWN)
            $display("read_data mismatch: expected %h actual %h",
                     expected_words[0], out_read_data);
        end
        void'(expected_words.pop_front());
      end
    end
  end

  // receiver stall pattern: alternating calm and stormy stretches
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_phase <= 0;
      out_stall <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[8]) out_stall <= ($urandom_range(0, 2) == 0);
      else out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted item or delivered result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  raster_item_t directed [$];

  initial begin
    int i, n;
    raster_item_t it;
    rst_n = 1'b0; in_valid = 1'b0; in_kind = ttr_pkg::KIND_DRAW;
    in_x0 = '0; in_y0 = '0; in_x1 = '0; in_y1 = '0; in_x2 = '0; in_y2 = '0;
    in_color = '0; in_read_index = '0;
    burst_left = 0;
    for (i = 0; i < ttr_pkg::STORE_WORDS; i++) shadow_store[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: cleared store, extremes, degenerate and flat cases
    directed.push_back(make_read(0, 1'b1, '0));
    directed.push_back(make_read(1023, 1'b1, '0));
    directed.push_back(make_draw(5, 9, 200, 9, 100, 9, 32'hFFFF_FFFF));
    directed.push_back(make_read(1, 1'b1, '0));
    directed.push_back(make_draw(0, 0, 255, 0, 0, 127, 32'hFFFF_FFFF));
    directed.push_back(make_draw(255, 127, 0, 127, 128, 0, 32'hA5A5_5A5A));
    directed.push_back(make_draw(3, 10, 3, 12, 3, 11, 32'h1234_5678));
    directed.push_back(make_draw(20, 40, 10, 40, 15, 50, 32'hFFFF_FFFF));
    directed.push_back(make_draw(30, 60, 20, 70, 40, 70, 32'h8888_8888));
    directed.push_back(make_draw(255, 0, 255, 127, 254, 64, 32'hFFFF_FFFF));
    directed.push_back(make_draw(0, 127, 1, 0, 0, 126, 32'h0000_0000));
    directed.push_back(make_draw(17, 100, 9, 101, 30, 100, 32'h7777_7777));
    directed.push_back(make_read(0, 1'b0, '0));
    directed.push_back(make_read(255, 1'b0, '0));
    directed.push_back(make_read(768 + 255, 1'b0, '0));
    directed.push_back(make_read(512 + 7, 1'b0, '0));
    directed.push_back(make_read(256 + 130, 1'b0, '0));
    foreach (directed[k]) send_item(directed[k]);

    // hold off until everything is back
    drain_results();

    // random mix: about one item in three is a draw, the rest are reads
    n = 0;
    while (n < 1150) begin
      if ($urandom_range(0, 2) == 0) it = random_draw();
      else it = make_read($urandom_range(0, 1023), 1'b0, '0);
      send_item(it);
      n++;
      if (n == 600) drain_results();
      sender_gap();
    end
    in_valid <= 1'b0;
    drain_results();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ttr_pkg.sv
src/ttr_div.sv
src/ttr_store.sv
src/tiled_triangle_rasterizer.sv
src/ttr_checker.sv
verif/tiled_triangle_rasterizer_tb.sv
